@@ rtl/aliw_pkg.sv @@
// Shared types, character codes and mnemonic tables for the instruction encoder.
`default_nettype none
package aliw_pkg;

  localparam int unsigned SEGMENT_CHARS_DEF = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] NUM_CLAMP = 16'd32768;
  localparam logic [15:0] NUM_MAX   = 16'd32767;
  localparam logic [2:0]  C_PREFIX  = 3'b111;

  localparam logic [1:0] ST_INSTR = 2'd0;
  localparam logic [1:0] ST_BLANK = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef enum logic [2:0] {
    SEC_START = 3'b001,
    SEC_ADDR  = 3'b010,
    SEC_COMP  = 3'b100
  } sec_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic [15:0] instr_word;
    logic [1:0]  line_status;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } lk_t;

  function automatic lk_t comp_lookup(input logic [3:0] len, input logic [31:0] txt);
    lk_t r;
    r.hit  = 1'b1;
    r.code = '0;
    unique case ({len, txt})
      {4'd1, 32'h00000030}: r.code = 7'h2A;
      {4'd1, 32'h00000031}: r.code = 7'h3F;
      {4'd2, 32'h00002D31}: r.code = 7'h3A;
      {4'd1, 32'h00000044}: r.code = 7'h0C;
      {4'd1, 32'h00000041}: r.code = 7'h30;
      {4'd1, 32'h0000004D}: r.code = 7'h70;
      {4'd2, 32'h00002144}: r.code = 7'h0D;
      {4'd2, 32'h00002141}: r.code = 7'h31;
      {4'd2, 32'h0000214D}: r.code = 7'h71;
      {4'd2, 32'h00002D44}: r.code = 7'h0F;
      {4'd2, 32'h00002D41}: r.code = 7'h33;
      {4'd2, 32'h00002D4D}: r.code = 7'h73;
      {4'd3, 32'h00442B31}: r.code = 7'h1F;
      {4'd3, 32'h00412B31}: r.code = 7'h37;
      {4'd3, 32'h004D2B31}: r.code = 7'h77;
      {4'd3, 32'h00442D31}: r.code = 7'h0E;
      {4'd3, 32'h00412D31}: r.code = 7'h32;
      {4'd3, 32'h004D2D31}: r.code = 7'h72;
      {4'd3, 32'h00442B41}: r.code = 7'h02;
      {4'd3, 32'h00442B4D}: r.code = 7'h42;
      {4'd3, 32'h00442D41}: r.code = 7'h13;
      {4'd3, 32'h00442D4D}: r.code = 7'h53;
      {4'd3, 32'h00412D44}: r.code = 7'h07;
      {4'd3, 32'h004D2D44}: r.code = 7'h47;
      {4'd3, 32'h00442641}: r.code = 7'h00;
      {4'd3, 32'h0044264D}: r.code = 7'h40;
      {4'd3, 32'h00447C41}: r.code = 7'h15;
      {4'd3, 32'h00447C4D}: r.code = 7'h55;
      default:              r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lk_t dest_lookup(input logic [3:0] len, input logic [31:0] txt);
    lk_t r;
    r.hit  = 1'b1;
    r.code = '0;
    unique case ({len, txt})
      {4'd4, 32'h6E756C6C}: r.code = 7'd0;
      {4'd1, 32'h0000004D}: r.code = 7'd1;
      {4'd1, 32'h00000044}: r.code = 7'd2;
      {4'd2, 32'h00004D44}: r.code = 7'd3;
      {4'd1, 32'h00000041}: r.code = 7'd4;
      {4'd2, 32'h0000414D}: r.code = 7'd5;
      {4'd2, 32'h00004144}: r.code = 7'd6;
      {4'd3, 32'h00414D44}: r.code = 7'd7;
      default:              r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lk_t jump_lookup(input logic [3:0] len, input logic [31:0] txt);
    lk_t r;
    r.hit  = 1'b1;
    r.code = '0;
    unique case ({len, txt})
      {4'd4, 32'h6E756C6C}: r.code = 7'd0;
      {4'd3, 32'h004A4754}: r.code = 7'd1;
      {4'd3, 32'h004A4551}: r.code = 7'd2;
      {4'd3, 32'h004A4745}: r.code = 7'd3;
      {4'd3, 32'h004A4C54}: r.code = 7'd4;
      {4'd3, 32'h004A4E45}: r.code = 7'd5;
      {4'd3, 32'h004A4C45}: r.code = 7'd6;
      {4'd3, 32'h004A4D50}: r.code = 7'd7;
      default:              r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/aliw_if.sv @@
// Valid/ready channel interfaces for source characters and encoded words.
`default_nettype none
interface aliw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface aliw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_word;
  logic [1:0]  line_status;

  modport source (output valid, output instr_word, output line_status, input ready);
  modport sink   (input valid, input instr_word, input line_status, output ready);
endinterface
`default_nettype wire

@@ rtl/assembly_line_to_instruction_word_unit.sv @@
// Top level of the assembly line to instruction word encoder.
// Usage:
//   in_ch carries one source character per word (char_code) with last_char
//   set on the final character of the line. Spaces and tabs are skipped and
//   a slash starts a comment that runs to the end of the line.
//   out_ch carries one word per line: instr_word and line_status
//   (instruction, blank/comment line, or error; instr_word is zero unless an
//   instruction). Characters other than the last produce no word.
//   Throughput: one character per cycle, sustained while no line end waits
//   on a held word, set by the single registered decode step between the
//   input register and the result register. The word for a line is formed
//   from its last character by the decode step and registered in the result
//   register, from which the receiver takes it.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   line state to the start of a line.
//   Receiver stall: characters that end no line keep flowing while a word
//   waits; a further line end is held in the input register and in_ch.ready
//   drops until the waiting word is taken.
`default_nettype none
module assembly_line_to_instruction_word_unit #(
  parameter int unsigned SEGMENT_CHARS = aliw_pkg::SEGMENT_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  aliw_in_if.sink    in_ch,
  aliw_out_if.source out_ch
);

  aliw_pkg::char_t in_data;
  aliw_pkg::char_t s1_data;
  aliw_pkg::res_t  res;
  aliw_pkg::res_t  out_data;
  logic            s1_valid;
  logic            take;
  logic            res_valid;
  logic            room;

  assign in_data.char_code = in_ch.char_code;
  assign in_data.last_char = in_ch.last_char;

  aliw_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_data),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  aliw_line_dec #(
    .SEGMENT_CHARS (SEGMENT_CHARS)
  ) u_line_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .out_room  (room),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  aliw_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.instr_word  = out_data.instr_word;
  assign out_ch.line_status = out_data.line_status;

endmodule
`default_nettype wire

@@ rtl/aliw_in_stage.sv @@
// Input register holding one source character until the line decoder takes it.
`default_nettype none
module aliw_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  aliw_pkg::char_t in_data,
  input  logic            take,
  output logic            s1_valid,
  output aliw_pkg::char_t s1_data
);

  logic            valid_r;
  logic            valid_nxt;
  aliw_pkg::char_t data_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);
  assign s1_valid  = valid_r;
  assign s1_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/aliw_line_dec.sv @@
// Line state and mnemonic decode: folds each character in and forms the word at line end.
`default_nettype none
module aliw_line_dec #(
  parameter int unsigned SEGMENT_CHARS = aliw_pkg::SEGMENT_CHARS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s1_valid,
  input  aliw_pkg::char_t s1_data,
  input  logic            out_room,
  output logic            take,
  output logic            res_valid,
  output aliw_pkg::res_t  res
);

  localparam int unsigned TW = 8 * SEGMENT_CHARS;
  localparam int unsigned LW = $clog2(SEGMENT_CHARS + 1);
  localparam logic [LW-1:0] SEG_MAX = LW'(SEGMENT_CHARS);

  aliw_pkg::sec_t sec_r, sec_nxt;
  logic [15:0]    num_r, num_nxt;
  logic           digit_r, digit_nxt;
  logic [TW-1:0]  text_r, text_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic           seen_a_r, seen_a_nxt;
  logic           seen_s_r, seen_s_nxt;
  logic [2:0]     dest_r, dest_nxt;
  logic [6:0]     comp_r, comp_nxt;
  logic           bad_r, bad_nxt;
  logic           cmt_r, cmt_nxt;

  logic [7:0]     ch;
  logic [18:0]    prod;
  aliw_pkg::lk_t  dest_cur, comp_cur, comp_fin, jump_fin;
  logic [6:0]     comp_use;

  assign ch   = s1_data.char_code;
  assign take = s1_valid && (!s1_data.last_char || out_room);
  assign prod = 19'(num_r) * 19'd10 + 19'(ch[3:0]);

  assign dest_cur = aliw_pkg::dest_lookup(4'(len_r), text_r[31:0]);
  assign comp_cur = aliw_pkg::comp_lookup(4'(len_r), text_r[31:0]);
  assign comp_fin = aliw_pkg::comp_lookup(4'(len_nxt), text_nxt[31:0]);
  assign jump_fin = aliw_pkg::jump_lookup(4'(len_nxt), text_nxt[31:0]);

  always_comb begin
    sec_nxt    = sec_r;
    num_nxt    = num_r;
    digit_nxt  = digit_r;
    text_nxt   = text_r;
    len_nxt    = len_r;
    seen_a_nxt = seen_a_r;
    seen_s_nxt = seen_s_r;
    dest_nxt   = dest_r;
    comp_nxt   = comp_r;
    bad_nxt    = bad_r;
    cmt_nxt    = cmt_r;
    if (!cmt_r && ch != aliw_pkg::CH_SPACE && ch != aliw_pkg::CH_TAB) begin
      if (ch == aliw_pkg::CH_SLASH) begin
        cmt_nxt = 1'b1;
      end else if (sec_r == aliw_pkg::SEC_ADDR) begin
        if (ch >= aliw_pkg::CH_ZERO && ch <= aliw_pkg::CH_NINE) begin
          num_nxt   = (prod > 19'(aliw_pkg::NUM_CLAMP)) ? aliw_pkg::NUM_CLAMP : prod[15:0];
          digit_nxt = 1'b1;
        end else begin
          bad_nxt = 1'b1;
        end
      end else if (sec_r == aliw_pkg::SEC_START && ch == aliw_pkg::CH_AT) begin
        sec_nxt = aliw_pkg::SEC_ADDR;
      end else begin
        sec_nxt = aliw_pkg::SEC_COMP;
        if (ch == aliw_pkg::CH_EQ) begin
          if (seen_a_r || seen_s_r) begin
            bad_nxt = 1'b1;
          end else begin
            seen_a_nxt = 1'b1;
            if (dest_cur.hit) begin
              dest_nxt = dest_cur.code[2:0];
            end else begin
              bad_nxt = 1'b1;
            end
            text_nxt = '0;
            len_nxt  = '0;
          end
        end else if (ch == aliw_pkg::CH_SEMI) begin
          if (seen_s_r) begin
            bad_nxt = 1'b1;
          end else begin
            seen_s_nxt = 1'b1;
            if (comp_cur.hit) begin
              comp_nxt = comp_cur.code;
            end else begin
              bad_nxt = 1'b1;
            end
            text_nxt = '0;
            len_nxt  = '0;
          end
        end else if (len_r >= SEG_MAX) begin
          bad_nxt = 1'b1;
        end else begin
          text_nxt = {text_r[TW-9:0], ch};
          len_nxt  = len_r + LW'(1);
        end
      end
    end
  end

  always_comb begin
    res             = '0;
    res.line_status = aliw_pkg::ST_ERROR;
    comp_use        = seen_s_nxt ? comp_nxt : comp_fin.code;
    unique case (sec_nxt)
      aliw_pkg::SEC_START: begin
        res.line_status = aliw_pkg::ST_BLANK;
      end
      aliw_pkg::SEC_ADDR: begin
        if (!bad_nxt && digit_nxt && num_nxt <= aliw_pkg::NUM_MAX) begin
          res.instr_word  = num_nxt;
          res.line_status = aliw_pkg::ST_INSTR;
        end
      end
      aliw_pkg::SEC_COMP: begin
        if (!bad_nxt && (seen_s_nxt ? jump_fin.hit : comp_fin.hit)) begin
          res.instr_word  = {aliw_pkg::C_PREFIX, comp_use, dest_nxt,
                             seen_s_nxt ? jump_fin.code[2:0] : 3'b000};
          res.line_status = aliw_pkg::ST_INSTR;
        end
      end
      default: begin
        res.line_status = aliw_pkg::ST_ERROR;
      end
    endcase
  end

  assign res_valid = take && s1_data.last_char;

  always_ff @(posedge clk) begin
    if (!rst_n || (take && s1_data.last_char)) begin
      sec_r    <= aliw_pkg::SEC_START;
      num_r    <= '0;
      digit_r  <= 1'b0;
      text_r   <= '0;
      len_r    <= '0;
      seen_a_r <= 1'b0;
      seen_s_r <= 1'b0;
      dest_r   <= '0;
      comp_r   <= '0;
      bad_r    <= 1'b0;
      cmt_r    <= 1'b0;
    end else if (take) begin
      sec_r    <= sec_nxt;
      num_r    <= num_nxt;
      digit_r  <= digit_nxt;
      text_r   <= text_nxt;
      len_r    <= len_nxt;
      seen_a_r <= seen_a_nxt;
      seen_s_r <= seen_s_nxt;
      dest_r   <= dest_nxt;
      comp_r   <= comp_nxt;
      bad_r    <= bad_nxt;
      cmt_r    <= cmt_nxt;
    end
  end

  a_clear_after_line: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (sec_r == aliw_pkg::SEC_START && len_r == '0 && !bad_r))
    else $error("line state not cleared after result");

  a_zero_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.line_status != aliw_pkg::ST_INSTR) |-> res.instr_word == 16'd0)
    else $error("non-zero word with non-instruction status");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= SEG_MAX)
    else $error("segment length beyond limit");

  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    num_r <= aliw_pkg::NUM_CLAMP)
    else $error("number accumulator beyond clamp");

endmodule
`default_nettype wire

@@ rtl/aliw_out_stage.sv @@
// Result register holding one encoded word until the receiver takes it.
`default_nettype none
module aliw_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  aliw_pkg::res_t load_data,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output aliw_pkg::res_t out_data
);

  logic           valid_r;
  logic           valid_nxt;
  aliw_pkg::res_t data_r;

  assign room      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || out_ready))
    else $error("word loaded over an undelivered word");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the assembly line to instruction word encoder: directed and random lines.
module tb;
  import aliw_pkg::*;

  localparam int SEG        = SEGMENT_CHARS_DEF;
  localparam int QUIET_MAX  = 4000;
  localparam int HOLD_OFF   = 400;
  localparam int SETTLE     = 4;

  typedef enum {TAB_DEST, TAB_COMP, TAB_JUMP} mnem_tab_t;

  logic clk;
  logic rst_n;

  aliw_in_if  in_ch ();
  aliw_out_if out_ch ();

  assembly_line_to_instruction_word_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  string comp_names [28] = '{"0", "1", "-1", "D", "A", "M", "!D", "!A", "!M", "-D", "-A",
                             "-M", "D+1", "A+1", "M+1", "D-1", "A-1", "M-1", "D+A", "D+M",
                             "D-A", "D-M", "A-D", "M-D", "D&A", "D&M", "D|A", "D|M"};
  logic [6:0] comp_vals [28] = '{7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h70, 7'h0D, 7'h31,
                                 7'h71, 7'h0F, 7'h33, 7'h73, 7'h1F, 7'h37, 7'h77, 7'h0E,
                                 7'h32, 7'h72, 7'h02, 7'h42, 7'h13, 7'h53, 7'h07, 7'h47,
                                 7'h00, 7'h40, 7'h15, 7'h55};
  string dest_names [8] = '{"null", "M", "D", "MD", "A", "AM", "AD", "AMD"};
  string jump_names [8] = '{"null", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};

  // line state of the encoder model
  sec_t               line_sec;
  logic [15:0]        num_acc;
  logic [8*SEG-1:0]   part_txt;
  logic [2:0]         part_len;
  logic               got_eq;
  logic               got_semi;
  logic [2:0]         dest_code;
  logic [6:0]         comp_code;
  logic               line_bad;
  logic               in_remark;

  res_t       words_due [$];
  logic [7:0] line_buf [$];
  int         send_idle_pct;
  int         recv_idle_pct;
  logic       out_hold;
  int         errors;
  int         quiet_cycles;

  function automatic void clear_line();
    line_sec  = SEC_START;
    num_acc   = '0;
    part_txt  = '0;
    part_len  = '0;
    got_eq    = 1'b0;
    got_semi  = 1'b0;
    dest_code = '0;
    comp_code = '0;
    line_bad  = 1'b0;
    in_remark = 1'b0;
  endfunction

  function automatic logic find_mnemonic(input mnem_tab_t sel, output logic [6:0] code);
    string            key;
    logic [8*SEG-1:0] pk;
    int               n;
    int               i;
    int               j;
    code = '0;
    n = (sel == TAB_COMP) ? 28 : 8;
    for (i = 0; i < n; i++) begin
      if (sel == TAB_COMP) key = comp_names[i];
      else if (sel == TAB_DEST) key = dest_names[i];
      else key = jump_names[i];
      pk = '0;
      for (j = 0; j < key.len(); j++) pk = {pk[8*SEG-9:0], 8'(key[j])};
      if (key.len() == int'(part_len) && pk == part_txt) begin
        code = (sel == TAB_COMP) ? comp_vals[i] : 7'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void take_part_char(input logic [7:0] c);
    logic [6:0] code;
    if (c == CH_EQ) begin
      if (got_eq || got_semi) begin
        line_bad = 1'b1;
        return;
      end
      got_eq = 1'b1;
      if (find_mnemonic(TAB_DEST, code)) dest_code = code[2:0];
      else line_bad = 1'b1;
      part_txt = '0;
      part_len = '0;
    end else if (c == CH_SEMI) begin
      if (got_semi) begin
        line_bad = 1'b1;
        return;
      end
      got_semi = 1'b1;
      if (find_mnemonic(TAB_COMP, code)) comp_code = code;
      else line_bad = 1'b1;
      part_txt = '0;
      part_len = '0;
    end else if (int'(part_len) >= SEG) begin
      line_bad = 1'b1;
    end else begin
      part_txt = {part_txt[8*SEG-9:0], c};
      part_len = part_len + 3'd1;
    end
  endfunction

  function automatic void encode_char(input logic [7:0] c, input logic last,
                                      output logic emit, output res_t w);
    int         v;
    logic [6:0] code;
    logic [2:0] jmp;
    emit = 1'b0;
    w.instr_word  = '0;
    w.line_status = ST_ERROR;
    if (!in_remark && c != CH_SPACE && c != CH_TAB) begin
      if (c == CH_SLASH) begin
        in_remark = 1'b1;
      end else if (line_sec == SEC_START) begin
        if (c == CH_AT) begin
          line_sec = SEC_ADDR;
        end else begin
          line_sec = SEC_COMP;
          take_part_char(c);
        end
      end else if (line_sec == SEC_ADDR) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          v = int'(num_acc) * 10 + int'(c) - int'(CH_ZERO);
          num_acc = (v > int'(NUM_CLAMP)) ? NUM_CLAMP : 16'(v);
          part_len = 3'd1;
        end else begin
          line_bad = 1'b1;
        end
      end else begin
        take_part_char(c);
      end
    end
    if (!last) return;
    emit = 1'b1;
    if (line_sec == SEC_START) begin
      w.line_status = ST_BLANK;
    end else if (line_sec == SEC_ADDR) begin
      if (!line_bad && part_len != 0 && num_acc <= NUM_MAX) begin
        w.instr_word  = num_acc;
        w.line_status = ST_INSTR;
      end
    end else begin
      jmp = '0;
      if (got_semi) begin
        if (find_mnemonic(TAB_JUMP, code)) jmp = code[2:0];
        else line_bad = 1'b1;
      end else begin
        if (find_mnemonic(TAB_COMP, code)) comp_code = code;
        else line_bad = 1'b1;
      end
      if (!line_bad) begin
        w.instr_word  = {C_PREFIX, comp_code, dest_code, jmp};
        w.line_status = ST_INSTR;
      end
    end
    clear_line();
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold) out_ch.ready = 1'b0;
      else out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word, instr_word %h line_status %0d", $time,
                 out_ch.instr_word, out_ch.line_status);
        errors++;
      end else begin
        exp_w = words_due.pop_front();
        if (out_ch.instr_word !== exp_w.instr_word) begin
          $display("%0t: instr_word expected %h, got %h", $time, exp_w.instr_word,
                   out_ch.instr_word);
          errors++;
        end
        if (out_ch.line_status !== exp_w.line_status) begin
          $display("%0t: line_status expected %0d, got %0d", $time, exp_w.line_status,
                   out_ch.line_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    logic emit;
    res_t w;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.char_code = c;
    in_ch.last_char = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_char(c, last, emit, w);
    if (emit) words_due.push_back(w);
    @(negedge clk);
  endtask

  task automatic send_buf(inout int sent);
    int i;
    for (i = 0; i < line_buf.size(); i++) begin
      send_char(line_buf[i], i == line_buf.size() - 1);
      sent++;
    end
  endtask

  task automatic load_text(input string s);
    int i;
    line_buf.delete();
    for (i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
  endtask

  task automatic wait_words_done();
    in_ch.valid = 1'b0;
    while (words_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic make_random_line();
    string      s;
    logic [7:0] tmp [$];
    int         kind;
    int         v;
    int         pos;
    int         i;
    s = "";
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      case ($urandom_range(0, 9))
        0:       v = 32767;
        1:       v = 32768;
        2:       v = $urandom_range(32768, 999999);
        3:       v = 0;
        default: v = $urandom_range(0, 32767);
      endcase
      s = {"@", $sformatf("%0d", v)};
    end else if (kind < 95 && kind >= 30 && !(kind >= 80 && kind < 85)) begin
      v = $urandom_range(0, 8);
      if (v < 8) s = {dest_names[v], "="};
      s = {s, comp_names[$urandom_range(0, 27)]};
      v = $urandom_range(0, 8);
      if (v < 8) s = {s, ";", jump_names[v]};
    end
    load_text(s);
    if (kind >= 85 && kind < 95) begin
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 4))
        0:       line_buf[pos] = 8'($urandom_range(0, 255));
        1:       line_buf.insert(pos, CH_EQ);
        2:       line_buf.insert(pos, CH_SEMI);
        3:       repeat ($urandom_range(1, 4)) line_buf.insert(pos, line_buf[pos]);
        default: line_buf.delete(pos);
      endcase
    end else if (kind >= 95) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    // scatter whitespace, tack on a comment now and then
    for (i = 0; i < line_buf.size(); i++) begin
      if ($urandom_range(0, 7) == 0) tmp.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      tmp.push_back(line_buf[i]);
    end
    if ($urandom_range(0, 5) == 0) begin
      tmp.push_back(CH_SLASH);
      repeat ($urandom_range(0, 5)) tmp.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) tmp.push_back(CH_SPACE);
    if (tmp.size() == 0) tmp.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    line_buf = tmp;
  endtask

  task automatic test_fixed_lines();
    string lines [$];
    int    sent;
    lines = '{"@0", "@32767", "@32768", "@99999", "@", "@1x", "@ 0 4\t2", "AMD=D|M;JMP",
              "null=D+1;null", "0;JEQ", "M", "D=", "=D", ";JMP", "D;", "A=D=M", "0;JMP=D",
              "D;JGT;JLT", "DDDDD=A", "ADM=A", "D=M+2", "  // note", "/", " \t "};
    sent = 0;
    send_idle_pct = 24;
    recv_idle_pct = 49;
    foreach (lines[i]) begin
      load_text(lines[i]);
      send_buf(sent);
    end
    line_buf = '{8'h00, 8'h44};
    send_buf(sent);
    line_buf = '{8'hFF};
    send_buf(sent);
    wait_words_done();
  endtask

  task automatic test_random_stream(input int snd_pct, input int rcv_pct, input int target);
    int sent;
    sent = 0;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    while (sent < target) begin
      make_random_line();
      send_buf(sent);
    end
    wait_words_done();
  endtask

  task automatic test_output_holdoff();
    int sent;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        out_hold = 1'b1;
        repeat (HOLD_OFF) @(negedge clk);
        out_hold = 1'b0;
      end
      begin
        repeat (30) begin
          make_random_line();
          send_buf(sent);
        end
      end
    join
    wait_words_done();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    out_hold        = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    errors          = 0;
    quiet_cycles    = 0;
    clear_line();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_fixed_lines();
    test_random_stream(24, 49, 330);
    test_random_stream(49, 24, 330);
    test_random_stream(0, 0, 330);
    test_output_holdoff();
    if (errors == 0 && words_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
